FILE: design/assert_macros.svh
// assertion macros used by the route table checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, masked while reset is asserted
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define AST_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/aodv_rt_pkg.sv
// shared constants, types and helpers for the route table engine
`default_nettype none
package aodv_rt_pkg;

  localparam int ROUTE_SLOTS = 16;
  localparam int SLOT_W      = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int MAX_OUT     = 16;
  localparam int CNT_W       = $clog2(MAX_OUT + 1);
  localparam int ADDR_W      = 32;
  localparam int SEQ_W       = 32;
  localparam int TIME_W      = 32;
  localparam int MET_W       = 8;
  localparam int CFG_W       = 20;
  localparam int ACT_W       = 3;
  localparam int STS_W       = 3;
  localparam int CFG_IDX_W   = 1;

  // actions
  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LBREAK = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd4;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd1;
  localparam logic [STS_W-1:0] STS_STALE_SEQ = 3'd2;
  localparam logic [STS_W-1:0] STS_WORSE     = 3'd3;
  localparam logic [STS_W-1:0] STS_BAD_NBR   = 3'd4;
  localparam logic [STS_W-1:0] STS_FULL      = 3'd5;
  localparam logic [STS_W-1:0] STS_NO_BREAK  = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETE_PERIOD  = 1'd1;

  localparam logic [CFG_W-1:0] ACTIVE_TIMEOUT_RST = 20'd3000;
  localparam logic [CFG_W-1:0] DELETE_PERIOD_RST  = 20'd15000;

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              scan;
    logic              exec;
    logic              flush;
    logic [SLOT_W-1:0] idx;
  } rt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic act_ok;
    logic is_lb;
  } rt_sts_t;

  // serial compare: a later than b
  function automatic logic later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage
`default_nettype wire

FILE: design/aodv_rt_ctrl.sv
// controller: sequences load, slot scan and final result step
`default_nettype none
module aodv_rt_ctrl import aodv_rt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire rt_sts_t sts,
  output rt_cmd_t      cmd,
  output logic         busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && sts.act_ok) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_r == SLOT_W'(ROUTE_SLOTS - 1)) begin
          state_nxt = sts.is_lb ? ST_FLUSH : ST_EXEC;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

FILE: design/aodv_rt_dpath.sv
// datapath: slot storage, sweep and action logic, result register
`default_nettype none
module aodv_rt_dpath import aodv_rt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rt_cmd_t           cmd,
  output rt_sts_t                sts,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [ADDR_W-1:0] in_dest_ip,
  input  wire logic [ADDR_W-1:0] in_hop_ip,
  input  wire logic [MET_W-1:0]  in_hop_count,
  input  wire logic [SEQ_W-1:0]  in_seq_number,
  input  wire logic              in_neighbor_ok,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  output logic                   out_strobe,
  output logic [STS_W-1:0]       out_status,
  output logic [ADDR_W-1:0]      out_route_dest,
  output logic [ADDR_W-1:0]      out_route_hop,
  output logic [MET_W-1:0]       out_route_metric,
  output logic [SEQ_W-1:0]       out_route_seq,
  output logic                   out_usable,
  output logic                   out_last
);

  // slot storage
  logic [ROUTE_SLOTS-1:0] used_r, valid_r;
  logic [ADDR_W-1:0]      dest_m [ROUTE_SLOTS];
  logic [ADDR_W-1:0]      hop_m  [ROUTE_SLOTS];
  logic [MET_W-1:0]       met_m  [ROUTE_SLOTS];
  logic [SEQ_W-1:0]       seq_m  [ROUTE_SLOTS];
  logic [TIME_W-1:0]      life_m [ROUTE_SLOTS];

  logic [CFG_W-1:0]  at_r, dp_r;
  logic [TIME_W-1:0] now_r;

  // latched transaction
  logic [ACT_W-1:0]  act_r;
  logic [ADDR_W-1:0] adest_r, ahop_r;
  logic [MET_W-1:0]  amet_r;
  logic [SEQ_W-1:0]  aseq_r;
  logic              anok_r;

  // scan results
  logic              found_v_r, free_v_r;
  logic [SLOT_W-1:0] found_idx_r, free_idx_r;
  logic              pend_v_r;
  logic [ADDR_W-1:0] pend_dest_r;
  logic [SEQ_W-1:0]  pend_seq_r;
  logic [CNT_W-1:0]  n_r;

  // result register
  logic              o_stb_r, o_last_r, o_use_r;
  logic [STS_W-1:0]  o_sts_r;
  logic [ADDR_W-1:0] o_dest_r, o_hop_r;
  logic [MET_W-1:0]  o_met_r;
  logic [SEQ_W-1:0]  o_seq_r;

  logic [SLOT_W-1:0] addr;
  logic              e_used, e_valid;
  logic [ADDR_W-1:0] e_dest, e_hop;
  logic [MET_W-1:0]  e_met;
  logic [SEQ_W-1:0]  e_seq;
  logic [TIME_W-1:0] e_life;
  logic [TIME_W-1:0] exp_life, act_life;
  logic              stale, s_valid, lb_hit, lb_exp;
  logic [SEQ_W-1:0]  s_seq, w_seq;
  logic [TIME_W-1:0] w_life;
  logic              upd_stale, upd_worse, upd_ok;

  assign sts.act_ok = (in_action == ACT_UPDATE) || (in_action == ACT_LOOKUP) ||
                      (in_action == ACT_DELETE) || (in_action == ACT_LBREAK) ||
                      (in_action == ACT_TICK);
  assign sts.is_lb  = (act_r == ACT_LBREAK);

  // single slot read port
  assign addr    = cmd.exec ? (found_v_r ? found_idx_r : free_idx_r) : cmd.idx;
  assign e_used  = used_r[addr];
  assign e_valid = valid_r[addr];
  assign e_dest  = dest_m[addr];
  assign e_hop   = hop_m[addr];
  assign e_met   = met_m[addr];
  assign e_seq   = seq_m[addr];
  assign e_life  = life_m[addr];

  assign exp_life = now_r + TIME_W'(dp_r);
  assign act_life = now_r + TIME_W'(at_r);

  // per-slot sweep, then link break expiry on the swept entry
  always_comb begin
    stale   = e_used && e_valid && later(now_r, e_life);
    s_valid = e_valid && !stale;
    s_seq   = e_seq + SEQ_W'(stale);
    lb_hit  = sts.is_lb && e_used && (e_hop == ahop_r);
    lb_exp  = lb_hit && s_valid;
    w_seq   = e_seq + SEQ_W'({1'b0, stale} + {1'b0, lb_exp});
    w_life  = (stale || lb_exp) ? exp_life : e_life;
  end

  // update checks on the entry found by the scan
  always_comb begin
    upd_stale = found_v_r && later(e_seq, aseq_r);
    upd_worse = found_v_r && e_valid && (aseq_r == e_seq) && (amet_r >= e_met);
    upd_ok    = anok_r && !upd_stale && !upd_worse && (found_v_r || free_v_r);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_r <= ACTIVE_TIMEOUT_RST;
      dp_r <= DELETE_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE_TIMEOUT: at_r <= cfg_data;
        CFG_DELETE_PERIOD:  dp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // used and valid flags, time base
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      valid_r <= '0;
      now_r   <= '0;
    end else begin
      if (cmd.load && (in_action == ACT_TICK)) begin
        now_r <= now_r + 1'b1;
      end
      if (cmd.scan) begin
        valid_r[addr] <= lb_hit ? 1'b0 : s_valid;
      end
      if (cmd.exec && (act_r == ACT_UPDATE) && upd_ok) begin
        used_r[addr]  <= 1'b1;
        valid_r[addr] <= 1'b1;
      end
      if (cmd.exec && (act_r == ACT_DELETE) && found_v_r) begin
        used_r[addr]  <= 1'b0;
        valid_r[addr] <= 1'b0;
      end
    end
  end

  // slot payload memory
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      seq_m[addr]  <= w_seq;
      life_m[addr] <= w_life;
    end
    if (cmd.exec && (act_r == ACT_UPDATE) && upd_ok) begin
      dest_m[addr] <= adest_r;
      hop_m[addr]  <= ahop_r;
      met_m[addr]  <= amet_r;
      seq_m[addr]  <= aseq_r;
      life_m[addr] <= act_life;
    end
  end

  // transaction latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      adest_r <= in_dest_ip;
      ahop_r  <= in_hop_ip;
      amet_r  <= in_hop_count;
      aseq_r  <= in_seq_number;
      anok_r  <= in_neighbor_ok;
    end
  end

  // scan trackers and link break holding entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_v_r <= 1'b0;
      free_v_r  <= 1'b0;
      pend_v_r  <= 1'b0;
      n_r       <= '0;
    end else if (cmd.load) begin
      found_v_r <= 1'b0;
      free_v_r  <= 1'b0;
      pend_v_r  <= 1'b0;
      n_r       <= '0;
    end else if (cmd.scan) begin
      if (!found_v_r && e_used && (e_dest == adest_r)) begin
        found_v_r   <= 1'b1;
        found_idx_r <= addr;
      end
      if (!free_v_r && !e_used) begin
        free_v_r   <= 1'b1;
        free_idx_r <= addr;
      end
      if (lb_hit && (n_r < CNT_W'(MAX_OUT))) begin
        pend_v_r    <= 1'b1;
        pend_dest_r <= e_dest;
        pend_seq_r  <= s_seq;
        n_r         <= n_r + 1'b1;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_stb_r <= 1'b0;
    end else begin
      o_stb_r <= cmd.exec || cmd.flush ||
                 (cmd.scan && lb_hit && pend_v_r && (n_r < CNT_W'(MAX_OUT)));
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    o_sts_r  <= STS_OK;
    o_dest_r <= '0;
    o_hop_r  <= '0;
    o_met_r  <= '0;
    o_seq_r  <= '0;
    o_use_r  <= 1'b0;
    o_last_r <= 1'b1;
    if (cmd.scan) begin
      o_dest_r <= pend_dest_r;
      o_hop_r  <= ahop_r;
      o_seq_r  <= pend_seq_r;
      o_last_r <= 1'b0;
    end else if (cmd.flush) begin
      if (pend_v_r) begin
        o_dest_r <= pend_dest_r;
        o_hop_r  <= ahop_r;
        o_seq_r  <= pend_seq_r;
      end else begin
        o_sts_r <= STS_NO_BREAK;
      end
    end else if (cmd.exec) begin
      unique case (act_r)
        ACT_UPDATE: begin
          o_dest_r <= adest_r;
          if (!anok_r) begin
            o_sts_r <= STS_BAD_NBR;
          end else if (upd_stale) begin
            o_sts_r <= STS_STALE_SEQ;
          end else if (upd_worse) begin
            o_sts_r <= STS_WORSE;
          end else if (!upd_ok) begin
            o_sts_r <= STS_FULL;
          end else begin
            o_hop_r <= ahop_r;
            o_met_r <= amet_r;
            o_seq_r <= aseq_r;
            o_use_r <= later(act_life, now_r);
          end
        end
        ACT_LOOKUP: begin
          if (found_v_r) begin
            o_dest_r <= e_dest;
            o_hop_r  <= e_hop;
            o_met_r  <= e_met;
            o_seq_r  <= e_seq;
            o_use_r  <= e_valid && later(e_life, now_r);
          end else begin
            o_sts_r  <= STS_NOT_FOUND;
            o_dest_r <= adest_r;
          end
        end
        ACT_DELETE: begin
          o_dest_r <= adest_r;
          if (!found_v_r) begin
            o_sts_r <= STS_NOT_FOUND;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_strobe       = o_stb_r;
  assign out_status       = o_sts_r;
  assign out_route_dest   = o_dest_r;
  assign out_route_hop    = o_hop_r;
  assign out_route_metric = o_met_r;
  assign out_route_seq    = o_seq_r;
  assign out_usable       = o_use_r;
  assign out_last         = o_last_r;

endmodule
`default_nettype wire

FILE: design/aodv_route_table_engine_unit.sv
// Route table engine top level. An item is taken when start is high,
// busy is low and in_action is a legal action code. Its steps are: latch
// the item and advance the clock on a tick, scan each slot in turn
// through the single slot read/write port (expiry sweep and the
// search or link break run together on each slot), and produce the
// final result. Results appear on out_strobe for exactly one cycle each and
// must be taken then; a link break streams its results during the scan,
// the one marked out_last arriving last. Configuration writes are always
// taken and should only be issued while busy is low.
`default_nettype none
module aodv_route_table_engine_unit import aodv_rt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ACT_W-1:0]     in_action,
  input  wire logic [ADDR_W-1:0]    in_dest_ip,
  input  wire logic [ADDR_W-1:0]    in_hop_ip,
  input  wire logic [MET_W-1:0]     in_hop_count,
  input  wire logic [SEQ_W-1:0]     in_seq_number,
  input  wire logic                 in_neighbor_ok,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      out_strobe,
  output logic [STS_W-1:0]          out_status,
  output logic [ADDR_W-1:0]         out_route_dest,
  output logic [ADDR_W-1:0]         out_route_hop,
  output logic [MET_W-1:0]          out_route_metric,
  output logic [SEQ_W-1:0]          out_route_seq,
  output logic                      out_usable,
  output logic                      out_last
);

  rt_cmd_t cmd;
  rt_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  aodv_rt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table and result datapath
  aodv_rt_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_dest_ip       (in_dest_ip),
    .in_hop_ip        (in_hop_ip),
    .in_hop_count     (in_hop_count),
    .in_seq_number    (in_seq_number),
    .in_neighbor_ok   (in_neighbor_ok),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_route_dest   (out_route_dest),
    .out_route_hop    (out_route_hop),
    .out_route_metric (out_route_metric),
    .out_route_seq    (out_route_seq),
    .out_usable       (out_usable),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

FILE: design/aodv_rt_checker.sv
// port-level checker for the route table engine and its bind
`default_nettype none
`include "assert_macros.svh"
module aodv_rt_checker import aodv_rt_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [ACT_W-1:0] in_action,
  input wire logic             out_strobe,
  input wire logic [STS_W-1:0] out_status,
  input wire logic             out_usable,
  input wire logic             out_last
);

  logic legal_act;

  // action codes that run a scan
  assign legal_act = (in_action == ACT_UPDATE) || (in_action == ACT_LOOKUP) ||
                     (in_action == ACT_DELETE) || (in_action == ACT_LBREAK) ||
                     (in_action == ACT_TICK);

  // a legal action starts a scan
  `AST_NXT(a_start_busy, start && !busy && legal_act, busy)
  // no-break result ends its transaction
  `AST_NOW(a_nobreak_last, out_strobe && (out_status == STS_NO_BREAK), out_last)
  // only ok results can be usable
  `AST_NOW(a_usable_ok, out_strobe && out_usable, out_status == STS_OK)
  // reset leaves the block quiet
  `AST_RST(a_reset_quiet, !rst_n, !busy && !out_strobe)

endmodule

bind aodv_route_table_engine_unit aodv_rt_checker u_chk (.*);
`default_nettype wire
